@@ design/prime_sieve_counter_core_defines.svh @@
// ----------------------------------------------------------------------------
// Prime sieve counter assertion macros
// Shared property shapes for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef PRIME_SIEVE_COUNTER_CORE_DEFINES_SVH
`define PRIME_SIEVE_COUNTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// Prime sieve counter package
// Field widths, constants and the controller state type of the core.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

   // Transaction field widths.
   localparam int LIMIT_W = 17;
   localparam int COUNT_W = 16;

   // The count saturates at its all-ones value.
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Smallest prime; also the largest limit that yields no primes.
   localparam int FIRST_PRIME = 2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_BASE_RD,
      ST_BASE_CHK,
      ST_MULT,
      ST_COUNT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ design/psc_req_if.sv @@
// ----------------------------------------------------------------------------
// Prime sieve counter request channel
// Valid/ready channel that carries the query limit.
// ----------------------------------------------------------------------------
`default_nettype none

interface psc_req_if;
   import psc_pkg::*;

   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] limit;

   modport source (output valid, output limit, input ready);
   modport sink   (input valid, input limit, output ready);
endinterface

`default_nettype wire

@@ design/psc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Prime sieve counter response channel
// Valid/ready channel that carries the prime count of one query.
// ----------------------------------------------------------------------------
`default_nettype none

interface psc_rsp_if;
   import psc_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] prime_count;

   modport source (output valid, output prime_count, input ready);
   modport sink   (input valid, input prime_count, output ready);
endinterface

`default_nettype wire

@@ design/psc_ram.sv @@
// ----------------------------------------------------------------------------
// Prime sieve counter RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/prime_sieve_counter_core.sv @@
// One query at a time: no new query is accepted until the last answer has been loaded
//   into the response register. The sieve phases share the single mark memory; a limit
//   of 2 or less skips the sieve and goes straight to the answer.
// Reset: synchronous, clears the sequencer and the response valid flag; the mark
//   memory is not cleared, since each query rewrites every entry below its limit.
// ----------------------------------------------------------------------------
// Prime sieve counter core
// Counts the primes below a query limit with a Sieve of Eratosthenes run over
// a one-bit-per-number mark memory.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_sieve_counter_core #(
   parameter int MAX_LIMIT = 65536
) (
   input  logic      clock,
   input  logic      reset,
   psc_req_if.sink   req_if,
   psc_rsp_if.source rsp_if
);
   import psc_pkg::*;

   localparam int AW = $clog2(MAX_LIMIT);
   localparam int NW = $clog2(MAX_LIMIT + 1);
   localparam int XW = NW + 1;
   localparam int CW = (NW > LIMIT_W) ? NW : LIMIT_W;

   state_type state_ff, state_in;

   logic [NW-1:0]      n_ff, n_in;
   logic [NW-1:0]      k_ff, k_in;
   logic [XW-1:0]      base_ff, base_in;
   logic [XW-1:0]      square_ff, square_in;
   logic [XW-1:0]      mult_ff, mult_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               req_fire;
   logic [CW-1:0]      limit_ext;
   logic               limit_small;
   logic [NW-1:0]      limit_sat;
   logic               k_below_n;
   logic               square_below_n;
   logic               mult_below_n;
   logic               rsp_load;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [0:0]         wr_data;
   logic [AW-1:0]      rd_addr;
   logic [0:0]         rd_data;

   // Limit handling: saturate to the store size, flag limits with no primes.
   assign req_fire    = req_if.valid && req_if.ready;
   assign limit_ext   = CW'(req_if.limit);
   assign limit_small = limit_ext <= CW'(FIRST_PRIME);
   assign limit_sat   = (limit_ext > CW'(MAX_LIMIT)) ? NW'(MAX_LIMIT) : NW'(limit_ext);

   // Loop bound compares.
   assign k_below_n      = k_ff < n_ff;
   assign square_below_n = square_ff < XW'(n_ff);
   assign mult_below_n   = mult_ff < XW'(n_ff);

   assign rsp_load = !rsp_valid_ff || rsp_if.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = limit_small ? ST_DONE : ST_INIT;
            end
         end
         ST_INIT: begin
            if (!k_below_n) begin
               state_in = ST_BASE_RD;
            end
         end
         ST_BASE_RD: begin
            state_in = square_below_n ? ST_BASE_CHK : ST_COUNT;
         end
         ST_BASE_CHK: begin
            state_in = rd_data[0] ? ST_MULT : ST_BASE_RD;
         end
         ST_MULT: begin
            if (!mult_below_n) begin
               state_in = ST_BASE_RD;
            end
         end
         ST_COUNT: begin
            if (!k_below_n && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath: loop indices, running count and the response register.
   always_comb begin
      n_in         = n_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      square_in    = square_ff;
      mult_in      = mult_ff;
      count_in     = count_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               n_in      = limit_sat;
               k_in      = '0;
               base_in   = XW'(FIRST_PRIME);
               square_in = XW'(FIRST_PRIME * FIRST_PRIME);
               count_in  = '0;
            end
         end
         ST_INIT: begin
            if (k_below_n) begin
               k_in = k_ff + NW'(1);
            end else begin
               k_in = NW'(FIRST_PRIME);
            end
         end
         ST_BASE_RD: begin
            mult_in = square_ff;
         end
         ST_BASE_CHK: begin
            // An unmarked base is skipped: step to the next base and its square.
            if (!rd_data[0]) begin
               base_in   = base_ff + XW'(1);
               square_in = square_ff + XW'({base_ff, 1'b1});
            end
         end
         ST_MULT: begin
            if (mult_below_n) begin
               mult_in = mult_ff + base_ff;
            end else begin
               base_in   = base_ff + XW'(1);
               square_in = square_ff + XW'({base_ff, 1'b1});
            end
         end
         ST_COUNT: begin
            // Reads issue back to back; each mark returns in the following cycle.
            if (k_below_n) begin
               k_in    = k_ff + NW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff && rd_data[0] && (count_ff != COUNT_MAX)) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Memory and handshake outputs.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = k_ff[AW-1:0];
      wr_data = 1'b1;
      rd_addr = k_ff[AW-1:0];
      unique case (state_ff)
         ST_INIT: begin
            // Entries 0 and 1 are not prime; everything else starts marked.
            wr_en   = k_below_n;
            wr_data = (k_ff >= NW'(FIRST_PRIME));
         end
         ST_BASE_RD: begin
            rd_addr = base_ff[AW-1:0];
         end
         ST_MULT: begin
            wr_en   = mult_below_n;
            wr_addr = mult_ff[AW-1:0];
            wr_data = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.prime_count = rsp_count_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      k_ff         <= k_in;
      base_ff      <= base_in;
      square_ff    <= square_in;
      mult_ff      <= mult_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Mark memory, one bit per number.
   psc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_LIMIT)
   ) u_marks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

@@ design/psc_checker.sv @@
// ----------------------------------------------------------------------------
// Prime sieve counter port checker
// Concurrent checks on the core's ports, attached to the core by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "prime_sieve_counter_core_defines.svh"

module psc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [psc_pkg::COUNT_W-1:0] prime_count
);

   // A query occupies the core, so no second transaction follows directly.
   `PSC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "core accepted a request while busy")

   // Reset leaves the core idle with no response pending.
   `PSC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, req_ready && !rsp_valid, "core not idle after reset")

   // A stalled response stays offered.
   `PSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // A stalled response keeps its count.
   `PSC_ASSERT_SAME(a_rsp_stable, clock, reset, $past(rsp_valid && !rsp_ready) && !$past(reset), $stable(prime_count), "response changed while stalled")

endmodule

bind prime_sieve_counter_core psc_checker u_psc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .prime_count (rsp_if.prime_count)
);

`default_nettype wire

@@ bench/psc_answer_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prime sieve counter answer checker
// Watches the query and answer channels of the core. Every accepted query is
// run through a software sieve, and its prime count is queued; every accepted
// answer is compared with the oldest queued count.
// ----------------------------------------------------------------------------

module psc_answer_checker #(
   parameter int MAX_LIMIT = 65536
) (
   input  logic        clock,
   input  logic        reset,
   psc_req_if          req_mon,
   psc_rsp_if          rsp_mon,
   output int unsigned failures,
   output int unsigned answers_owed
);
   import psc_pkg::*;

   localparam int SHOWN_MISMATCHES = 10;

   typedef struct packed {
      logic [LIMIT_W-1:0] limit;
      logic [COUNT_W-1:0] prime_count;
   } owed_answer_type;

   // Sieve state, kept the way the core keeps it.
   bit                 sieve_marks [0:MAX_LIMIT-1];
   logic [LIMIT_W-1:0] sieve_base     = '0;
   logic [LIMIT_W-1:0] sieve_multiple = '0;
   logic [COUNT_W-1:0] prime_tally    = '0;

   owed_answer_type owed_answers [$];
   int unsigned     mismatch_count = 0;

   initial begin
      failures     = 0;
      answers_owed = 0;
   end

   // Sieve the numbers below the (saturated) limit and count what is left.
   function automatic logic [COUNT_W-1:0] count_primes_below(
      input logic [LIMIT_W-1:0] raw_limit
   );
      int unsigned n;
      int unsigned k;
      int unsigned b;
      int unsigned m;
      n = raw_limit;
      if (n > MAX_LIMIT) begin
         n = MAX_LIMIT;
      end
      // Small limits leave the sieve state alone.
      if (n <= FIRST_PRIME) begin
         return '0;
      end
      for (k = 0; k < n; k++) begin
         sieve_marks[k] = 1'b1;
      end
      sieve_marks[0] = 1'b0;
      sieve_marks[1] = 1'b0;
      for (b = FIRST_PRIME; b * b < n; b++) begin
         if (sieve_marks[b]) begin
            for (m = b * b; m < n; m += b) begin
               sieve_marks[m] = 1'b0;
            end
            sieve_multiple = m[LIMIT_W-1:0];
         end
      end
      sieve_base = b[LIMIT_W-1:0];
      prime_tally = '0;
      for (k = FIRST_PRIME; k < n; k++) begin
         if (sieve_marks[k] && prime_tally != COUNT_MAX) begin
            prime_tally++;
         end
      end
      return prime_tally;
   endfunction

   function automatic void log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES) begin
         $display("%0t: answer mismatch: %s", $realtime, what);
      end
   endfunction

   // Check answers first, so a query accepted on the same edge is never
   // matched with its own answer.
   always @(posedge clock) begin
      owed_answer_type oldest;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_answers.size() == 0) begin
               log_mismatch($sformatf("unexpected transaction, prime_count %0d",
                                      rsp_mon.prime_count));
            end else begin
               oldest = owed_answers.pop_front();
               if (rsp_mon.prime_count !== oldest.prime_count) begin
                  log_mismatch($sformatf("limit %0d expected prime_count %0d, got %0d",
                                         oldest.limit, oldest.prime_count,
                                         rsp_mon.prime_count));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            owed_answers.push_back('{limit: req_mon.limit,
                                     prime_count: count_primes_below(req_mon.limit)});
         end
      end
      failures     <= mismatch_count;
      answers_owed <= owed_answers.size();
   end

endmodule

@@ bench/prime_sieve_counter_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prime sieve counter core testbench
// Sends directed and random query limits to the core, with random gaps on the
// query side and random stalls on the answer side, and lets the checker
// compare every prime count it returns.
// ----------------------------------------------------------------------------

module prime_sieve_counter_core_tb;
   import psc_pkg::*;

   localparam int MAX_LIMIT      = 65536;
   localparam int RANDOM_QUERIES = 78;
   localparam int IDLE_PERCENT   = 28;
   localparam int DRAIN_CYCLES   = 16;
   // Allow several times the run of a full-size query.
   localparam int QUIET_LIMIT    = 1500000;

   logic clock  = 1'b0;
   logic reset  = 1'b1;
   bit   steady = 1'b0;

   int unsigned failures;
   int unsigned answers_owed;

   psc_req_if req_ch ();
   psc_rsp_if rsp_ch ();

   // Limits at the edges of the sieve: small cases, squares of primes, and
   // the all-ones limit, which saturates to the largest size.
   logic [LIMIT_W-1:0] directed_limits [0:21] = '{
      17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9,
      17'd10, 17'd11, 17'd12, 17'd25, 17'd26, 17'd49, 17'd50, 17'd121,
      17'd122, 17'd256, 17'd1024, 17'h1FFFF
   };

   prime_sieve_counter_core #(
      .MAX_LIMIT(MAX_LIMIT)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   psc_answer_checker #(
      .MAX_LIMIT(MAX_LIMIT)
   ) answer_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .failures     (failures),
      .answers_owed (answers_owed)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The answer side stalls at random, except during the steady stretch.
   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Offer one query, after a random gap, and hold it until it is accepted.
   task automatic send_query(input logic [LIMIT_W-1:0] limit);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.limit <= limit;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   // Lower valid and wait for every owed answer to come back.
   task automatic wait_for_answers();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (answers_owed != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int unsigned pick;
      logic [LIMIT_W-1:0] limit;
      req_ch.valid = 1'b0;
      req_ch.limit = '0;
      rsp_ch.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed queries.
      foreach (directed_limits[i]) begin
         send_query(directed_limits[i]);
      end

      // Random queries: mostly small limits to keep sieve runs short.
      for (int i = 0; i < RANDOM_QUERIES; i++) begin
         steady = (i >= 30 && i < 60);
         if (i == 70) begin
            wait_for_answers();
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            limit = $urandom_range(0, 300);
         end else if (pick < 90) begin
            limit = $urandom_range(301, 2048);
         end else begin
            limit = $urandom_range(2049, 8192);
         end
         send_query(limit);
      end
      steady = 1'b0;

      // Drain and give the verdict.
      wait_for_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && answers_owed == 0) begin
         $display("PASS prime_sieve_counter_core");
      end else begin
         $display("FAIL prime_sieve_counter_core");
      end
      $finish;
   end

   // End the run when no transaction moves for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("FAIL prime_sieve_counter_core");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/psc_pkg.sv
design/psc_req_if.sv
design/psc_rsp_if.sv
design/psc_ram.sv
design/prime_sieve_counter_core.sv
design/psc_checker.sv
bench/psc_answer_checker.sv
bench/prime_sieve_counter_core_tb.sv
